### hw/rtl/gbe_pkg.sv
// ----------------------------------------------------------------------------
// gbe_pkg
// shared constants, codes and control types of the gap buffer editor
// ----------------------------------------------------------------------------
package gbe_pkg;

  localparam int DEPTH_DEF       = 1024;
  localparam int INITIAL_GAP_DEF = 1024;

  localparam int MODE_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 11;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 24;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RIGHT  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_AT_START  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_AT_END    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_GAP_EMPTY = 2'd3;

  typedef struct packed {
    logic clear;
    logic exec;
    logic move;
    logic emit;
  } gbe_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic copy;
  } gbe_sts_t;

endpackage

### hw/rtl/gbe_ctrl.sv
// ----------------------------------------------------------------------------
// gbe_ctrl
// sequencer: clearing pass, word accept, move step, result handoff
// ----------------------------------------------------------------------------
module gbe_ctrl import gbe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  input  gbe_sts_t sts_i,
  output gbe_cmd_t cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_MOVE  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       valid_q, valid_d;
  logic       out_free;
  logic       accept;
  logic       emit;

  assign out_free  = !valid_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = valid_q;

  assign emit = out_free && ((accept && !sts_i.copy) || (state_q == S_MOVE) ||
                             (state_q == S_FIN));

  assign cmd_o.clear = (state_q == S_CLEAR);
  assign cmd_o.exec  = accept;
  assign cmd_o.move  = (state_q == S_MOVE);
  assign cmd_o.emit  = emit;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (sts_i.copy) state_d = S_MOVE;
          else if (!out_free) state_d = S_FIN;
        end
      end
      S_MOVE: begin
        state_d = out_free ? S_IDLE : S_FIN;
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (emit) valid_d = 1'b1;
    else if (m_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

endmodule

### hw/rtl/gbe_datapath.sv
// ----------------------------------------------------------------------------
// gbe_datapath
// text store, gap pointers and result register
// ----------------------------------------------------------------------------
module gbe_datapath import gbe_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int INITIAL_GAP = INITIAL_GAP_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbe_cmd_t            cmd_i,
  output gbe_sts_t            sts_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [CHAR_W-1:0]   char_i,
  output logic [M_DATA_W-1:0] out_data_o
);

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int XW      = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int GapInit = (INITIAL_GAP > DEPTH) ? DEPTH : INITIAL_GAP;

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rdata_q;

  // gap spans first_q .. end_q-1, empty when both are equal
  logic [CW-1:0] first_q, first_d, end_q, end_d;
  logic [CW-1:0] first_p1, first_m1, end_p1, end_m1;
  logic          dir_q, dir_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [AW-1:0] clr_cnt_q;
  logic [M_DATA_W-1:0] out_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [CHAR_W-1:0] wdata;
  logic          empty, at_front, at_end;
  logic [XW-1:0] first_x, last_x;

  assign first_p1 = first_q + CW'(1);
  assign first_m1 = first_q - CW'(1);
  assign end_p1   = end_q + CW'(1);
  assign end_m1   = end_q - CW'(1);

  assign empty    = (first_q == end_q);
  assign at_front = (first_q == '0);
  assign at_end   = (end_q == CW'(DEPTH));

  assign sts_o.clear_done = (clr_cnt_q == AW'(DEPTH - 1));
  assign sts_o.copy = !empty && (((mode_i == MODE_LEFT) && !at_front) ||
                                 ((mode_i == MODE_RIGHT) && !at_end));

  always_comb begin
    first_d  = first_q;
    end_d    = end_q;
    dir_d    = dir_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = first_q[AW-1:0];
    raddr    = first_m1[AW-1:0];
    wdata    = '0;
    if (cmd_i.clear) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
    end else if (cmd_i.exec) begin
      status_d = ST_DONE;
      case (mode_i)
        MODE_INSERT: begin
          if (empty) begin
            status_d = ST_GAP_EMPTY;
          end else begin
            we      = 1'b1;
            wdata   = char_i;
            first_d = first_p1;
          end
        end
        MODE_DELETE: begin
          if (at_front) begin
            status_d = ST_AT_START;
          end else begin
            we      = 1'b1;
            waddr   = first_m1[AW-1:0];
            first_d = first_m1;
          end
        end
        MODE_LEFT: begin
          if (at_front) begin
            status_d = ST_AT_START;
          end else if (empty) begin
            first_d = first_m1;
            end_d   = end_m1;
          end else begin
            we    = 1'b1;
            waddr = first_m1[AW-1:0];
            dir_d = 1'b0;
          end
        end
        default: begin
          if (at_end) begin
            status_d = ST_AT_END;
          end else if (empty) begin
            first_d = first_p1;
            end_d   = end_p1;
          end else begin
            we    = 1'b1;
            waddr = end_q[AW-1:0];
            raddr = end_q[AW-1:0];
            dir_d = 1'b1;
          end
        end
      endcase
    end else if (cmd_i.move) begin
      status_d = ST_DONE;
      we       = 1'b1;
      wdata    = rdata_q;
      if (dir_q) begin
        waddr   = first_q[AW-1:0];
        first_d = first_p1;
        end_d   = end_p1;
      end else begin
        waddr   = end_m1[AW-1:0];
        first_d = first_m1;
        end_d   = end_m1;
      end
    end
  end

  // read-first: a cell read and cleared in the same cycle gives its old byte
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= '0;
      end_q     <= CW'(GapInit);
      clr_cnt_q <= '0;
    end else begin
      first_q <= first_d;
      end_q   <= end_d;
      if (cmd_i.clear && !sts_o.clear_done) clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign first_x = XW'(first_d);
  assign last_x  = XW'(end_d) - XW'(1);

  always_ff @(posedge clk_i) begin
    dir_q    <= dir_d;
    status_q <= status_d;
    if (cmd_i.emit) out_q <= {last_x[FIELD_W-1:0], first_x[FIELD_W-1:0], status_d};
  end

  assign out_data_o = out_q;

endmodule

### hw/rtl/gap_buffer_editor.sv
// ----------------------------------------------------------------------------
// gap_buffer_editor
// fixed-capacity gap buffer of bytes with insert, delete and cursor moves
// ----------------------------------------------------------------------------
// After reset the store is cleared one cell per cycle, so s_axis_tready stays
// low until every cell is cleared. Insert, delete, rejected words and moves
// across an empty gap are executed on accept; a move that carries a byte also
// passes through the move state, since the single write port of the store
// must clear the source cell and then write the byte at the far end of the
// gap. Each word gives one result word holding the status and both gap ends;
// the result register lets the next word enter while a result still waits.
module gap_buffer_editor import gbe_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int INITIAL_GAP = INITIAL_GAP_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // mode[1:0], character[9:2]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata   // status[1:0], cursor_pos[12:2], gap_last[23:13]
);

  gbe_cmd_t cmd;
  gbe_sts_t sts;

  gbe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gbe_datapath #(
    .DEPTH       (DEPTH),
    .INITIAL_GAP (INITIAL_GAP)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .mode_i     (s_axis_tdata[MODE_W-1:0]),
    .char_i     (s_axis_tdata[MODE_W+CHAR_W-1:MODE_W]),
    .out_data_o (m_axis_tdata)
  );

endmodule

### hw/rtl/gbe_checker.sv
// ----------------------------------------------------------------------------
// gbe_checker
// port-level checks of the gap buffer editor, bound to the top level
// ----------------------------------------------------------------------------
module gbe_checker import gbe_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [S_DATA_W-1:0] s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata
);

  logic [STATUS_W-1:0] st;
  logic [FIELD_W-1:0]  cur, last;

  assign st   = m_axis_tdata[STATUS_W-1:0];
  assign cur  = m_axis_tdata[STATUS_W+FIELD_W-1:STATUS_W];
  assign last = m_axis_tdata[STATUS_W+2*FIELD_W-1:STATUS_W+FIELD_W];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_insert_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[MODE_W-1:0] == MODE_INSERT) &&
    (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
    else $error("insert result not issued in next cycle");

  a_empty_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_GAP_EMPTY) |-> (last == cur - FIELD_W'(1)))
    else $error("gap empty status with nonempty gap");

  a_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == ST_AT_START) |-> (cur == '0))
    else $error("rejected at start with cursor away from front");

endmodule

bind gap_buffer_editor gbe_checker u_gbe_checker (.*);
